// ===== hw/rtl/tcst_pkg.sv =====
// tcst_pkg: shared types and constants for the touch contact slot tracker
// used by tcst_alu, tcst_ram users and the top level
// no dependencies
package tcst_pkg;

    localparam int MAX_CONTACTS_DEF = 64;

    localparam int ID_W    = 16;
    localparam int RAW_W   = 20;
    localparam int ORIG_W  = 15;
    localparam int POS_W   = 16;
    localparam int DELTA_W = 17;
    localparam int SLOT_OUT_W = 6;
    localparam int QUOT_W  = 14;

    // x / 100 == (x * DIV_RECIP) >> DIV_SHIFT for every 20-bit x
    localparam logic [RAW_W-1:0] DIV_RECIP = 20'd671089;
    localparam int DIV_SHIFT = 26;

    typedef enum logic [0:0] {
        ALU_DIV100 = 1'b0,
        ALU_SUB    = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op                   op;
        logic [RAW_W-1:0]          ua;
        logic signed [DELTA_W-1:0] sa;
        logic signed [DELTA_W-1:0] sb;
    } t_alu_req;

    typedef struct packed {
        logic signed [POS_W-1:0]   cur_x;
        logic signed [POS_W-1:0]   cur_y;
        logic signed [POS_W-1:0]   prev_x;
        logic signed [POS_W-1:0]   prev_y;
        logic signed [DELTA_W-1:0] mov_x;
        logic signed [DELTA_W-1:0] mov_y;
    } t_slot_data;

    localparam t_slot_data SLOT_DATA_RESET = '{
        cur_x:  -16'sd1,
        cur_y:  -16'sd1,
        prev_x: -16'sd1,
        prev_y: -16'sd1,
        mov_x:  17'sd0,
        mov_y:  17'sd0
    };

endpackage

// ===== hw/rtl/tcst_ram.sv =====
// tcst_ram: generic single write, single read ram with registered read data
// depends on nothing
module tcst_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcst_alu.sv =====
// tcst_alu: shared arithmetic unit, divide by 100 or signed subtract
// depends on tcst_pkg
module tcst_alu
    import tcst_pkg::*;
(
    input  t_alu_req                   i_req,
    output logic signed [DELTA_W-1:0]  o_res
);

    logic [2*RAW_W-1:0]  prod;
    logic [QUOT_W-1:0]   quot;
    logic signed [DELTA_W-1:0] diff;

    // reciprocal multiply, exact over the whole raw range
    assign prod = i_req.ua * DIV_RECIP;
    assign quot = prod[DIV_SHIFT +: QUOT_W];
    assign diff = i_req.sa - i_req.sb;

    always_comb begin
        case (i_req.op)
            ALU_DIV100: o_res = $signed({{(DELTA_W-QUOT_W){1'b0}}, quot});
            ALU_SUB:    o_res = diff;
            default:    o_res = diff;
        endcase
    end

endmodule

// ===== hw/rtl/touch_contact_slot_tracker.sv =====
// touch_contact_slot_tracker: top level, sequencer, slot table and config registers
// depends on tcst_pkg, tcst_alu and tcst_ram
// raw coordinates are divided by 100 and the origins subtracted; id zero is then
// rejected, others scan the owners up to a hit or the last slot (a miss on a full
// table rejects); a lift then frees its slot, others form deltas and write back
// one beat in flight; the next beat is taken once the result has been taken
// synchronous active-low reset frees every slot and clears the origins to zero
module touch_contact_slot_tracker
    import tcst_pkg::*;
#(
    parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ID_W-1:0]            i_contact_id,
    input  logic                       i_lift,
    input  logic [RAW_W-1:0]           i_raw_x,
    input  logic [RAW_W-1:0]           i_raw_y,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_accepted,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic                       o_released,
    output logic signed [POS_W-1:0]    o_pos_x,
    output logic signed [POS_W-1:0]    o_pos_y,
    output logic signed [DELTA_W-1:0]  o_delta_x,
    output logic signed [DELTA_W-1:0]  o_delta_y,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int SLOT_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CONTACTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_CONTACTS - 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(MAX_CONTACTS);
    localparam int DATA_W = $bits(t_slot_data);

    // register index decoded from paddr[2]
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_DIVX = 12'b0000_0000_0010,
        S_DIVY = 12'b0000_0000_0100,
        S_ORGX = 12'b0000_0000_1000,
        S_ORGY = 12'b0000_0001_0000,
        S_SCAN = 12'b0000_0010_0000,
        S_RD   = 12'b0000_0100_0000,
        S_UPD  = 12'b0000_1000_0000,
        S_DX   = 12'b0001_0000_0000,
        S_DY   = 12'b0010_0000_0000,
        S_WR   = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;

    // config registers
    logic signed [ORIG_W-1:0] r_origin_x;
    logic signed [ORIG_W-1:0] r_origin_y;
    logic                     cfg_wr;

    // captured beat
    logic [ID_W-1:0]  r_id;
    logic             r_lift;
    logic [RAW_W-1:0] r_raw_x;
    logic [RAW_W-1:0] r_raw_y;

    // working position: quotient first, then client coordinate
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;

    // slot table: busy flags in flops, owner and position data in ram
    logic [MAX_CONTACTS-1:0] r_busy;

    // owner scan
    logic [CNT_W-1:0]  r_idx;
    logic              r_chk_v;
    logic [SLOT_W-1:0] r_chk_idx;
    logic              r_free_v;
    logic [SLOT_W-1:0] r_free_idx;
    logic [SLOT_W-1:0] r_slot;
    logic              r_hit;
    logic [SLOT_W-1:0] scan_addr;
    logic              scan_hit;

    // update working set
    logic signed [POS_W-1:0]   r_prev_x;
    logic signed [POS_W-1:0]   r_prev_y;
    logic signed [DELTA_W-1:0] r_mov_x;
    logic signed [DELTA_W-1:0] r_mov_y;

    // result beat
    logic                      r_o_accepted;
    logic [SLOT_OUT_W-1:0]     r_o_slot;
    logic                      r_o_released;
    logic signed [POS_W-1:0]   r_o_pos_x;
    logic signed [POS_W-1:0]   r_o_pos_y;
    logic signed [DELTA_W-1:0] r_o_delta_x;
    logic signed [DELTA_W-1:0] r_o_delta_y;

    // ram ports
    logic [ID_W-1:0] owner_rdata;
    logic            owner_we;
    logic [DATA_W-1:0] data_rdata_raw;
    t_slot_data      data_rd;
    t_slot_data      slot_now;
    t_slot_data      data_wdata;
    logic            data_we;

    // shared alu
    t_alu_req                  alu_req;
    logic signed [DELTA_W-1:0] alu_res;

    //------------------------------------------------------------------
    // configuration port, writes land on the access phase
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ORIGIN_X) begin
                r_origin_x <= pwdata[ORIG_W-1:0];
            end else begin
                r_origin_y <= pwdata[ORIG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ORIGIN_Y) begin
            prdata = 32'(r_origin_y);
        end else begin
            prdata = 32'(r_origin_x);
        end
    end

    //------------------------------------------------------------------
    // shared alu operand select
    // divide raw x, raw y, then subtract the origins, then the deltas
    //------------------------------------------------------------------
    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.ua = r_raw_x;
        alu_req.sa = DELTA_W'(r_px);
        alu_req.sb = DELTA_W'(r_origin_x);
        case (r_state)
            S_DIVX: begin
                alu_req.op = ALU_DIV100;
                alu_req.ua = r_raw_x;
            end
            S_DIVY: begin
                alu_req.op = ALU_DIV100;
                alu_req.ua = r_raw_y;
            end
            S_ORGX: begin
                // quotient is non-negative, so zero extend
                alu_req.sa = $signed({1'b0, r_px});
                alu_req.sb = DELTA_W'(r_origin_x);
            end
            S_ORGY: begin
                alu_req.sa = $signed({1'b0, r_py});
                alu_req.sb = DELTA_W'(r_origin_y);
            end
            S_DX: begin
                alu_req.sa = DELTA_W'(r_px);
                alu_req.sb = DELTA_W'(r_prev_x);
            end
            S_DY: begin
                alu_req.sa = DELTA_W'(r_py);
                alu_req.sb = DELTA_W'(r_prev_y);
            end
            default: begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    tcst_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    //------------------------------------------------------------------
    // slot memories
    // a newly claimed slot takes reset data whatever the ram holds there
    //------------------------------------------------------------------
    assign scan_addr = r_idx[SLOT_W-1:0];
    assign owner_we  = (r_state == S_WR) && !r_hit;

    tcst_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_CONTACTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (owner_we),
        .i_waddr (r_slot),
        .i_wdata (r_id),
        .i_raddr (scan_addr),
        .o_rdata (owner_rdata)
    );

    assign data_we = ((r_state == S_UPD) && r_lift) || (r_state == S_WR);

    always_comb begin
        if (r_state == S_UPD) begin
            data_wdata = SLOT_DATA_RESET;
        end else begin
            data_wdata.cur_x  = r_px;
            data_wdata.cur_y  = r_py;
            data_wdata.prev_x = r_prev_x;
            data_wdata.prev_y = r_prev_y;
            data_wdata.mov_x  = r_mov_x;
            data_wdata.mov_y  = r_mov_y;
        end
    end

    tcst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_CONTACTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata (data_wdata),
        .i_raddr (r_slot),
        .o_rdata (data_rdata_raw)
    );

    assign data_rd  = t_slot_data'(data_rdata_raw);
    assign slot_now = r_hit ? data_rd : SLOT_DATA_RESET;

    // owner data arrives in the cycle after its scan address, in step with r_chk_idx
    assign scan_hit = r_chk_v && r_busy[r_chk_idx] && (owner_rdata == r_id);

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= '0;
            r_chk_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_id    <= i_contact_id;
                        r_lift  <= i_lift;
                        r_raw_x <= i_raw_x;
                        r_raw_y <= i_raw_y;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    r_px    <= POS_W'(alu_res);
                    r_state <= S_DIVY;
                end
                S_DIVY: begin
                    r_py    <= POS_W'(alu_res);
                    r_state <= S_ORGX;
                end
                S_ORGX: begin
                    r_px    <= POS_W'(alu_res);
                    r_state <= S_ORGY;
                end
                S_ORGY: begin
                    r_py       <= POS_W'(alu_res);
                    r_idx      <= '0;
                    r_chk_v    <= 1'b0;
                    r_free_v   <= 1'b0;
                    r_free_idx <= '0;
                    if (r_id == '0) begin
                        // id zero is rejected, all result fields zero
                        r_o_accepted <= 1'b0;
                        r_o_slot     <= '0;
                        r_o_released <= 1'b0;
                        r_o_pos_x    <= '0;
                        r_o_pos_y    <= '0;
                        r_o_delta_x  <= '0;
                        r_o_delta_y  <= '0;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue side: next owner read and first free slot
                    // the check flag is cleared again before the next scan starts
                    if (r_idx < CNT_END) begin
                        r_idx     <= r_idx + CNT_W'(1);
                        r_chk_v   <= 1'b1;
                        r_chk_idx <= scan_addr;
                        if (!r_busy[scan_addr] && !r_free_v) begin
                            r_free_v   <= 1'b1;
                            r_free_idx <= scan_addr;
                        end
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    // compare side
                    if (scan_hit) begin
                        r_slot  <= r_chk_idx;
                        r_hit   <= 1'b1;
                        r_state <= S_RD;
                    end else if (r_chk_v && (r_chk_idx == LAST_SLOT)) begin
                        if (r_free_v) begin
                            r_slot  <= r_free_idx;
                            r_hit   <= 1'b0;
                            r_state <= S_RD;
                        end else begin
                            // table full
                            r_o_accepted <= 1'b0;
                            r_o_slot     <= '0;
                            r_o_released <= 1'b0;
                            r_o_pos_x    <= '0;
                            r_o_pos_y    <= '0;
                            r_o_delta_x  <= '0;
                            r_o_delta_y  <= '0;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    // slot data read in flight
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_lift) begin
                        // clear and free; lift of an unknown id lands here too when a slot is free
                        r_busy[r_slot] <= 1'b0;
                        r_o_accepted   <= 1'b1;
                        r_o_slot       <= SLOT_OUT_W'(r_slot);
                        r_o_released   <= 1'b1;
                        r_o_pos_x      <= SLOT_DATA_RESET.cur_x;
                        r_o_pos_y      <= SLOT_DATA_RESET.cur_y;
                        r_o_delta_x    <= SLOT_DATA_RESET.mov_x;
                        r_o_delta_y    <= SLOT_DATA_RESET.mov_y;
                        r_state        <= S_OUT;
                    end else begin
                        // keep the old position only if its x is on screen
                        if (slot_now.cur_x > 0) begin
                            r_prev_x <= slot_now.cur_x;
                            r_prev_y <= slot_now.cur_y;
                        end else begin
                            r_prev_x <= slot_now.prev_x;
                            r_prev_y <= slot_now.prev_y;
                        end
                        r_mov_x <= slot_now.mov_x;
                        r_mov_y <= slot_now.mov_y;
                        r_state <= S_DX;
                    end
                end
                S_DX: begin
                    if (r_prev_x > 0) begin
                        r_mov_x <= alu_res;
                    end
                    r_state <= S_DY;
                end
                S_DY: begin
                    if (r_prev_x > 0) begin
                        r_mov_y <= alu_res;
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_busy[r_slot] <= 1'b1;
                    r_o_accepted   <= 1'b1;
                    r_o_slot       <= SLOT_OUT_W'(r_slot);
                    r_o_released   <= 1'b0;
                    r_o_pos_x      <= r_px;
                    r_o_pos_y      <= r_py;
                    r_o_delta_x    <= r_mov_x;
                    r_o_delta_y    <= r_mov_y;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // outputs
    //------------------------------------------------------------------
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_accepted = r_o_accepted;
    assign o_slot     = r_o_slot;
    assign o_released = r_o_released;
    assign o_pos_x    = r_o_pos_x;
    assign o_pos_y    = r_o_pos_y;
    assign o_delta_x  = r_o_delta_x;
    assign o_delta_y  = r_o_delta_y;

`ifndef SYNTH
    // a new beat is never taken while a result waits
    a_no_take_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("input taken while a result is pending");

    // one beat in flight: after a take the input side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second beat taken while one is in flight");

    // a freed slot is always a handled event
    a_release_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_released) |-> o_accepted)
        else $error("release reported on a rejected event");

    // rejected events carry all-zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_slot == '0) && (o_pos_x == '0) &&
            (o_pos_y == '0) && (o_delta_x == '0) && (o_delta_y == '0))
        else $error("rejected event with nonzero fields");

    // scan counter stays within the table plus one
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= CNT_END))
        else $error("owner scan ran past the table");
`endif

endmodule
